// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker files of this project.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/caldate_pkg.sv -----
// Package for the calendar date counter: command codes, controller states,
// control and status structs, field widths and month length helpers. No dependencies.
`timescale 1ns / 1ps

package caldate_pkg;

    localparam int unsigned YEAR_BITS_DEF = 16;
    localparam int unsigned S_DATA_W      = 48;
    localparam int unsigned S_USER_W      = 2;
    localparam int unsigned M_DATA_W      = 32;
    localparam int unsigned M_FIELDS_W    = 28;
    localparam int unsigned MOD_W         = 9;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_SUB  = 2'd2,
        CMD_CMP  = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MOD  = 2'd1,
        ST_STEP = 2'd2,
        ST_DONE = 2'd3
    } state_t;

    typedef struct packed {
        logic capture;
        logic mod_step;
        logic step;
        logic publish;
    } dp_ctrl_t;

    typedef struct packed {
        logic mod_last;
        logic count_zero;
        logic out_free;
    } dp_status_t;

    // The argument is the year modulo 400.
    function automatic logic leap_of_mod(input logic [MOD_W-1:0] r);
        logic m100;
        m100 = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
        return (r[1:0] == 2'b00) && !m100;
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/core/caldate_ctrl.sv -----
// Controller state machine of the calendar date counter.
// Depends on caldate_pkg; drives the control struct of caldate_dp.
`timescale 1ns / 1ps

module caldate_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             s_cmd,
    input  caldate_pkg::dp_status_t status,
    output caldate_pkg::dp_ctrl_t   ctrl
);
    import caldate_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (cmd_code_t'(s_cmd))
                        CMD_LOAD: state_next = ST_MOD;
                        CMD_ADD:  state_next = ST_STEP;
                        CMD_SUB:  state_next = ST_STEP;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_MOD:
            begin
                if (status.mod_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_STEP:
            begin
                if (status.count_zero)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        ctrl.capture  = (state_reg == ST_IDLE) && s_tvalid;
        ctrl.mod_step = (state_reg == ST_MOD);
        ctrl.step     = (state_reg == ST_STEP) && !status.count_zero;
        ctrl.publish  = (state_reg == ST_DONE) && status.out_free;
    end

endmodule

// ----- rtl/core/caldate_dp.sv -----
// Datapath of the calendar date counter: date registers, year-mod-400 tracker,
// day stepper, comparator and output register. Depends on caldate_pkg.
`timescale 1ns / 1ps

module caldate_dp #(
    parameter int unsigned YEAR_BITS = caldate_pkg::YEAR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [caldate_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [caldate_pkg::S_USER_W-1:0]  s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [caldate_pkg::M_DATA_W-1:0]  m_tdata,
    input  caldate_pkg::dp_ctrl_t             ctrl,
    output caldate_pkg::dp_status_t           status
);
    import caldate_pkg::*;

    localparam longint unsigned YEAR_SPAN  = 64'd1 << YEAR_BITS;
    localparam longint unsigned RESET_YEAR = 64'd2000 % YEAR_SPAN;
    localparam longint unsigned RESET_MOD  = RESET_YEAR % 64'd400;
    localparam longint unsigned MAX_MOD    = (YEAR_SPAN - 64'd1) % 64'd400;
    localparam int unsigned     MCW        = $clog2(YEAR_BITS + 1);

    logic [4:0]           in_day;
    logic [3:0]           in_month;
    logic [YEAR_BITS-1:0] in_year;
    logic [15:0]          day_count;

    logic [4:0]           day_reg,   day_next;
    logic [3:0]           month_reg, month_next;
    logic [YEAR_BITS-1:0] year_reg,  year_next;
    logic [MOD_W-1:0]     mod_reg,   mod_next;
    logic [YEAR_BITS-1:0] shift_reg;
    logic [MCW-1:0]       mcnt_reg;
    logic [15:0]          count_reg;
    cmd_code_t            cmd_reg;
    logic [4:0]           gday_reg;
    logic [3:0]           gmonth_reg;
    logic [YEAR_BITS-1:0] gyear_reg;
    logic                 out_valid_reg;
    logic [M_FIELDS_W-1:0] out_reg;

    logic [MOD_W:0]       mod_shift;
    logic [MOD_W-1:0]     mod_inc, mod_dec, mod_back;
    logic [4:0]           fwd_len, back_len;
    logic [5:0]           day_inc;
    logic [4:0]           month_inc;
    logic                 wrap_back;
    logic                 eq, after, earlier;

    assign in_day    = s_tdata[4:0];
    assign in_month  = s_tdata[8:5];
    assign in_year   = YEAR_BITS'(s_tdata[24:9]);
    assign day_count = s_tdata[40:25];

    assign mod_shift = {mod_reg, shift_reg[YEAR_BITS-1]};
    assign mod_inc   = (year_reg == {YEAR_BITS{1'b1}}) ? '0 :
                       (mod_reg == 9'd399) ? '0 : mod_reg + 9'd1;
    assign mod_dec   = (year_reg == '0) ? MOD_W'(MAX_MOD) :
                       (mod_reg == '0) ? 9'd399 : mod_reg - 9'd1;

    assign fwd_len   = month_length(month_reg, leap_of_mod(mod_reg));
    assign day_inc   = {1'b0, day_reg} + 6'd1;
    assign month_inc = {1'b0, month_reg} + 5'd1;
    assign wrap_back = (month_reg <= 4'd1);
    assign mod_back  = wrap_back ? mod_dec : mod_reg;
    assign back_len  = month_length(wrap_back ? 4'd12 : month_reg - 4'd1,
                                    leap_of_mod(mod_back));

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        mod_next   = mod_reg;
        if (ctrl.capture && (cmd_code_t'(s_tuser) == CMD_LOAD))
        begin
            day_next   = in_day;
            month_next = in_month;
            year_next  = in_year;
            mod_next   = '0;
        end
        else if (ctrl.mod_step)
        begin
            mod_next = (mod_shift >= 10'd400) ? MOD_W'(mod_shift - 10'd400)
                                              : MOD_W'(mod_shift);
        end
        else if (ctrl.step && (cmd_reg == CMD_ADD))
        begin
            if (day_inc > {1'b0, fwd_len})
            begin
                day_next = 5'd1;
                if (month_inc > 5'd12)
                begin
                    month_next = 4'd1;
                    year_next  = year_reg + YEAR_BITS'(1);
                    mod_next   = mod_inc;
                end
                else
                begin
                    month_next = month_inc[3:0];
                end
            end
            else
            begin
                day_next = day_inc[4:0];
            end
        end
        else if (ctrl.step)
        begin
            if (day_reg <= 5'd1)
            begin
                day_next = back_len;
                if (wrap_back)
                begin
                    month_next = 4'd12;
                    year_next  = year_reg - YEAR_BITS'(1);
                    mod_next   = mod_dec;
                end
                else
                begin
                    month_next = month_reg - 4'd1;
                end
            end
            else
            begin
                day_next = day_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= 5'd1;
            month_reg <= 4'd1;
            year_reg  <= RESET_YEAR[YEAR_BITS-1:0];
            mod_reg   <= MOD_W'(RESET_MOD);
            mcnt_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            mod_reg   <= mod_next;
            if (ctrl.capture)
            begin
                mcnt_reg  <= MCW'(YEAR_BITS);
                count_reg <= day_count;
            end
            else
            begin
                if (ctrl.mod_step)
                begin
                    mcnt_reg <= mcnt_reg - MCW'(1);
                end
                if (ctrl.step)
                begin
                    count_reg <= count_reg - 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg    <= cmd_code_t'(s_tuser);
            gday_reg   <= in_day;
            gmonth_reg <= in_month;
            gyear_reg  <= in_year;
            shift_reg  <= in_year;
        end
        else if (ctrl.mod_step)
        begin
            shift_reg <= shift_reg << 1;
        end
    end

    always_comb
    begin
        eq = (day_reg == gday_reg) && (month_reg == gmonth_reg) && (year_reg == gyear_reg);
        if (year_reg != gyear_reg)
        begin
            after = year_reg > gyear_reg;
        end
        else if (month_reg != gmonth_reg)
        begin
            after = month_reg > gmonth_reg;
        end
        else
        begin
            after = day_reg > gday_reg;
        end
        earlier = !after && !eq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.publish)
        begin
            out_reg <= {earlier && (cmd_reg == CMD_CMP),
                        after && (cmd_reg == CMD_CMP),
                        eq && (cmd_reg == CMD_CMP),
                        16'(year_reg), month_reg, day_reg};
        end
    end

    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = {{(M_DATA_W - M_FIELDS_W){1'b0}}, out_reg};
    assign status.mod_last   = (mcnt_reg == MCW'(1));
    assign status.count_zero = (count_reg == 16'd0);
    assign status.out_free   = !out_valid_reg || m_tready;

endmodule

// ----- rtl/core/calendar_date_up_down_counter.sv -----
// Top level of the calendar date counter: controller plus datapath.
// Depends on caldate_pkg, caldate_ctrl and caldate_dp.
//
// Channel | Direction | Contents
// s_      | in        | tuser: command; tdata: day, month, year, day count
// m_      | out       | tdata: day, month, year, equal, after, before
//
// A transaction occupies the block from acceptance until its result is written
// to the output register: compare goes straight to the result, add and subtract
// step one calendar day per cycle until the day count is used up, and load runs
// the bit-serial year-modulo-400 unit over every year bit to rebuild the leap state.
// Reset gives the date 1/1/2000. A stalled result holds the block in its final
// state; the next transaction is taken once the result register is free and the block is back in idle.
`timescale 1ns / 1ps

module calendar_date_up_down_counter #(
    parameter int unsigned YEAR_BITS = caldate_pkg::YEAR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [4:0] in_day, [8:5] in_month, [24:9] in_year, [40:25] day_count
    input  logic [caldate_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [caldate_pkg::S_USER_W-1:0]  s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [4:0] out_day, [8:5] out_month, [24:9] out_year, [25] is_equal,
    // [26] is_after, [27] is_before
    output logic [caldate_pkg::M_DATA_W-1:0]  m_tdata
);
    import caldate_pkg::*;

    dp_ctrl_t   ctrl;
    dp_status_t status;

    caldate_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .status   (status),
        .ctrl     (ctrl)
    );

    caldate_dp #(
        .YEAR_BITS (YEAR_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctrl     (ctrl),
        .status   (status)
    );

endmodule

// ----- rtl/core/caldate_checker.sv -----
// Port-level checker for the calendar date counter, bound to the top level.
// Depends on caldate_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module caldate_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [caldate_pkg::S_DATA_W-1:0]  s_tdata,
    input logic [caldate_pkg::S_USER_W-1:0]  s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [caldate_pkg::M_DATA_W-1:0]  m_tdata
);
    import caldate_pkg::*;

    logic s_fire;
    logic m_stall;

    assign s_fire  = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;

    `ASSERT_NEXT(a_out_valid_holds, clk, rst_n, m_stall, m_tvalid)
    `ASSERT_NEXT(a_out_data_holds, clk, rst_n, m_stall, $stable(m_tdata))
    `ASSERT_IMPL(a_flags_exclusive, clk, rst_n, m_tvalid, $onehot0(m_tdata[27:25]))
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_fire, !s_tready)

endmodule

bind calendar_date_up_down_counter caldate_checker u_caldate_checker (.*);
